[design/iees_pkg.sv]
// shared types and constants for the i2c eeprom image server
package iees_pkg;

   localparam logic [1:0] ACT_LOAD = 2'd0;
   localparam logic [1:0] ACT_BUS  = 2'd1;
   localparam logic [1:0] ACT_TICK = 2'd2;

   localparam logic [2:0] ST_RUNNING          = 3'd0;
   localparam logic [2:0] ST_DONE_OK          = 3'd1;
   localparam logic [2:0] ST_ARB_LOST         = 3'd2;
   localparam logic [2:0] ST_RESET_TIMEOUT    = 3'd3;
   localparam logic [2:0] ST_TRANSFER_TIMEOUT = 3'd4;
   localparam logic [2:0] ST_STOP_TIMEOUT     = 3'd5;

   localparam logic [1:0] CSR_RESET_TICKS    = 2'd0;
   localparam logic [1:0] CSR_TRANSFER_TICKS = 2'd1;
   localparam logic [1:0] CSR_FAST_INDEX     = 2'd2;

   localparam logic [15:0] RESET_TICKS_DEFAULT    = 16'd11;
   localparam logic [15:0] TRANSFER_TICKS_DEFAULT = 16'd12;
   localparam logic [15:0] FAST_INDEX_DEFAULT     = 16'd8;

   typedef enum logic [1:0] {
      PH_RUNNING   = 2'd0,
      PH_WAIT_STOP = 2'd1,
      PH_FINISHED  = 2'd2
   } phase_type;

   typedef struct packed {
      logic [1:0]  action;
      logic        arbitration_lost;
      logic        address_match;
      logic        slave_transmit;
      logic        master_nack;
      logic        bus_busy;
      logic [7:0]  rx_byte;
      logic [15:0] load_address;
      logic [7:0]  load_byte;
   } req_type;

   // one item on its way through the image pipeline
   typedef struct packed {
      logic        tx_valid;
      logic        transmit_mode;
      logic        fast_rate;
      logic [2:0]  status;
      logic        is_load;
      logic        load_ok;
      logic [7:0]  load_byte;
      logic [15:0] idx;
   } item_type;

   typedef struct packed {
      logic        tx_valid;
      logic [7:0]  tx_byte;
      logic        transmit_mode;
      logic        fast_rate;
      logic [2:0]  status;
   } rsp_type;

   typedef struct packed {
      phase_type   phase;
      logic        sending;
   } ctrl_stat_type;

endpackage

[design/iees_ram.sv]
// generic single-port ram with registered read
module iees_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic                     wr_en,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[design/iees_ctrl.sv]
// slave state machine, timeouts and configuration registers
module iees_ctrl #(
   parameter int IMAGE_DEPTH = 65536
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    item_accept,
   input  iees_pkg::req_type       req,
   input  logic                    csr_write,
   input  logic [1:0]              csr_index,
   input  logic [15:0]             csr_data,
   output iees_pkg::item_type      item_out,
   output iees_pkg::ctrl_stat_type stat
);

   localparam logic [16:0] DEPTH_W = 17'(IMAGE_DEPTH);

   iees_pkg::phase_type phase_ff, phase_in;
   logic [15:0] byte_index_ff, byte_index_in;
   logic        expect_high_ff, expect_high_in;
   logic        sending_ff, sending_in;
   logic        fast_ff, fast_in;
   logic [15:0] ticks_ff, ticks_in;
   logic [2:0]  status_ff, status_in;
   logic        bus_seen_ff, bus_seen_in;
   logic [15:0] reset_ticks_ff, reset_ticks_in;
   logic [15:0] xfer_ticks_ff, xfer_ticks_in;
   logic [15:0] fast_idx_ff, fast_idx_in;
   logic        tx_valid;
   logic        is_bus, is_tick, is_load, expired;

   assign is_bus  = item_accept && (req.action == iees_pkg::ACT_BUS);
   assign is_tick = item_accept && (req.action == iees_pkg::ACT_TICK);
   assign is_load = req.action == iees_pkg::ACT_LOAD;
   assign expired = ticks_ff <= 16'd1;

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         iees_pkg::PH_RUNNING: begin
            if (is_bus) begin
               if (req.arbitration_lost) begin
                  phase_in = iees_pkg::PH_FINISHED;
               end else if (!req.address_match && sending_ff && req.master_nack &&
                            byte_index_ff > 16'd1) begin
                  phase_in = iees_pkg::PH_WAIT_STOP;
               end
            end else if (is_tick && expired) begin
               phase_in = iees_pkg::PH_FINISHED;
            end
         end
         iees_pkg::PH_WAIT_STOP: begin
            if ((is_bus && !req.bus_busy) || (is_tick && expired)) begin
               phase_in = iees_pkg::PH_FINISHED;
            end
         end
         iees_pkg::PH_FINISHED: phase_in = iees_pkg::PH_FINISHED;
         default:               phase_in = phase_ff;
      endcase
   end

   // datapath updates per phase
   always_comb begin
      byte_index_in  = byte_index_ff;
      expect_high_in = expect_high_ff;
      sending_in     = sending_ff;
      fast_in        = fast_ff;
      ticks_in       = ticks_ff;
      status_in      = status_ff;
      bus_seen_in    = bus_seen_ff;
      reset_ticks_in = reset_ticks_ff;
      xfer_ticks_in  = xfer_ticks_ff;
      fast_idx_in    = fast_idx_ff;
      tx_valid       = 1'b0;
      unique case (phase_ff)
         iees_pkg::PH_RUNNING: begin
            if (is_bus) begin
               bus_seen_in = 1'b1;
               if (req.arbitration_lost) begin
                  status_in = iees_pkg::ST_ARB_LOST;
               end else if (req.address_match) begin
                  ticks_in = xfer_ticks_ff;
                  if (req.slave_transmit) begin
                     sending_in    = 1'b1;
                     tx_valid      = 1'b1;
                     byte_index_in = byte_index_ff + 16'd1;
                  end else begin
                     sending_in     = 1'b0;
                     byte_index_in  = '0;
                     expect_high_in = 1'b1;
                  end
               end else begin
                  // byte complete
                  ticks_in = xfer_ticks_ff;
                  if (byte_index_ff == fast_idx_ff) begin
                     fast_in = 1'b1;
                  end
                  if (sending_ff) begin
                     if (!req.master_nack) begin
                        tx_valid      = 1'b1;
                        byte_index_in = byte_index_ff + 16'd1;
                     end else begin
                        sending_in = 1'b0;
                     end
                  end else if (expect_high_ff) begin
                     byte_index_in  = {req.rx_byte, 8'h00};
                     expect_high_in = 1'b0;
                  end else begin
                     byte_index_in = byte_index_ff | {8'h00, req.rx_byte};
                  end
               end
            end else if (is_tick) begin
               if (expired) begin
                  status_in = (byte_index_ff != '0) ? iees_pkg::ST_TRANSFER_TIMEOUT
                                                    : iees_pkg::ST_RESET_TIMEOUT;
               end else begin
                  ticks_in = ticks_ff - 16'd1;
               end
            end
         end
         iees_pkg::PH_WAIT_STOP: begin
            if (is_bus && !req.bus_busy) begin
               status_in = iees_pkg::ST_DONE_OK;
            end else if (is_tick) begin
               if (expired) begin
                  status_in = iees_pkg::ST_STOP_TIMEOUT;
               end else begin
                  ticks_in = ticks_ff - 16'd1;
               end
            end
         end
         iees_pkg::PH_FINISHED: status_in = status_ff;
         default:               status_in = status_ff;
      endcase

      if (csr_write) begin
         case (csr_index)
            iees_pkg::CSR_RESET_TICKS: begin
               reset_ticks_in = csr_data;
               if (phase_ff == iees_pkg::PH_RUNNING && !bus_seen_ff) begin
                  ticks_in = csr_data;
               end
            end
            iees_pkg::CSR_TRANSFER_TICKS: xfer_ticks_in = csr_data;
            iees_pkg::CSR_FAST_INDEX:     fast_idx_in   = csr_data;
            default:                      fast_idx_in   = fast_idx_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff       <= iees_pkg::PH_RUNNING;
         byte_index_ff  <= '0;
         expect_high_ff <= 1'b1;
         sending_ff     <= 1'b0;
         fast_ff        <= 1'b0;
         ticks_ff       <= iees_pkg::RESET_TICKS_DEFAULT;
         status_ff      <= iees_pkg::ST_RUNNING;
         bus_seen_ff    <= 1'b0;
         reset_ticks_ff <= iees_pkg::RESET_TICKS_DEFAULT;
         xfer_ticks_ff  <= iees_pkg::TRANSFER_TICKS_DEFAULT;
         fast_idx_ff    <= iees_pkg::FAST_INDEX_DEFAULT;
      end else begin
         phase_ff       <= phase_in;
         byte_index_ff  <= byte_index_in;
         expect_high_ff <= expect_high_in;
         sending_ff     <= sending_in;
         fast_ff        <= fast_in;
         ticks_ff       <= ticks_in;
         status_ff      <= status_in;
         bus_seen_ff    <= bus_seen_in;
         reset_ticks_ff <= reset_ticks_in;
         xfer_ticks_ff  <= xfer_ticks_in;
         fast_idx_ff    <= fast_idx_in;
      end
   end

   // reads use the index before the increment, loads carry their own address
   always_comb begin
      item_out.tx_valid      = tx_valid;
      item_out.transmit_mode = sending_in;
      item_out.fast_rate     = fast_in;
      item_out.status        = status_in;
      item_out.is_load       = is_load;
      item_out.load_ok       = {1'b0, req.load_address} < DEPTH_W;
      item_out.load_byte     = req.load_byte;
      item_out.idx           = is_load ? req.load_address : byte_index_ff;
   end

   assign stat.phase   = phase_ff;
   assign stat.sending = sending_ff;

endmodule

[design/iees_pipe.sv]
// image pipeline: index reduction modulo the image depth, ram access, result stage
module iees_pipe #(
   parameter int IMAGE_DEPTH = 65536
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_ready,
   input  iees_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_ready,
   output iees_pkg::rsp_type  out_rsp
);

   localparam int          AW      = $clog2(IMAGE_DEPTH);
   localparam logic [16:0] DEPTH_W = 17'(IMAGE_DEPTH);
   // floor(2^32 / depth): quotient estimate is low by at most one
   localparam logic [32:0] RECIP   = 33'((64'd1 << 32) / IMAGE_DEPTH);

   logic               v1_ff, v2_ff, v3_ff, v4_ff;
   iees_pkg::item_type item1_ff, item2_ff, item3_ff, item4_ff;
   logic [7:0]         quot2_ff, quot2_in;
   logic [16:0]        prod3_ff, prod3_in;
   logic               en1, en2, en3, en4;
   logic [48:0]        recip_prod;
   logic [24:0]        back_prod;
   logic [16:0]        rem_raw, rem_fix;
   logic               ram_wr_en, ram_rd_en;
   logic [7:0]         ram_rd_data;

   assign en4 = !v4_ff || out_ready;
   assign en3 = !v3_ff || en4;
   assign en2 = !v2_ff || en3;
   assign en1 = !v1_ff || en2;
   assign in_ready = en1;

   assign recip_prod = 49'(item1_ff.idx) * 49'(RECIP);
   assign quot2_in   = recip_prod[39:32];
   assign back_prod  = 25'(quot2_ff) * 25'(DEPTH_W);
   assign prod3_in   = back_prod[16:0];

   assign rem_raw = {1'b0, item3_ff.idx} - prod3_ff;
   assign rem_fix = (rem_raw >= DEPTH_W) ? rem_raw - DEPTH_W : rem_raw;

   // at most one access per word, in arrival order, as it moves into the result stage
   assign ram_wr_en = v3_ff && en4 && item3_ff.is_load && item3_ff.load_ok;
   assign ram_rd_en = v3_ff && en4 && item3_ff.tx_valid;

   iees_ram #(
      .WIDTH (8),
      .DEPTH (IMAGE_DEPTH)
   ) u_image (
      .clock   (clock),
      .addr    (rem_fix[AW-1:0]),
      .wr_en   (ram_wr_en),
      .wr_data (item3_ff.load_byte),
      .rd_en   (ram_rd_en),
      .rd_data (ram_rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= in_valid;
         if (en2) v2_ff <= v1_ff;
         if (en3) v3_ff <= v2_ff;
         if (en4) v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) begin
         item1_ff <= in_item;
      end
      if (en2) begin
         item2_ff <= item1_ff;
         quot2_ff <= quot2_in;
      end
      if (en3) begin
         item3_ff <= item2_ff;
         prod3_ff <= prod3_in;
      end
      if (en4) begin
         item4_ff <= item3_ff;
      end
   end

   assign out_valid             = v4_ff;
   assign out_rsp.tx_valid      = item4_ff.tx_valid;
   assign out_rsp.tx_byte       = item4_ff.tx_valid ? ram_rd_data : 8'h00;
   assign out_rsp.transmit_mode = item4_ff.transmit_mode;
   assign out_rsp.fast_rate     = item4_ff.fast_rate;
   assign out_rsp.status        = item4_ff.status;

endmodule

[design/i2c_eeprom_slave_image_server_unit.sv]
// top level of the i2c eeprom image server
//
// req_ carries one word per item: load an image byte, report a bus event,
// or advance the timeout tick. Each accepted word gives exactly one rsp_
// word, in order: transmit byte if any, transmit mode, fast rate flag and
// the status code. csr_ writes the timeout and fast switch registers; it is
// always ready; the user must see that it is written only while the block
// is idle, as the block does not enforce this. Slave state is updated in
// the accept cycle; the word then passes a pipeline that reduces the image
// index modulo IMAGE_DEPTH (multiply by a reciprocal, multiply back, one
// correction) and reaches the single-port image ram, which takes one read
// or write per cycle. A word passes the input, quotient, back-product and
// result registers before rsp_tvalid. Throughput: one word per cycle unless
// the receiver stalls, limited by the single image ram port. Reset clears
// all control state and reloads the default registers; the image ram is not
// cleared and holds undefined bytes until loaded. If the receiver stalls,
// up to four words are held in the pipeline before req_tready drops.
module i2c_eeprom_slave_image_server_unit #(
   parameter int IMAGE_DEPTH = 65536
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // [0] arbitration_lost, [1] address_match, [2] slave_transmit,
   // [3] master_nack, [4] bus_busy, [12:5] rx_byte, [28:13] load_address,
   // [36:29] load_byte, [39:37] zero
   input  logic [39:0] req_tdata,
   // [1:0] action
   input  logic [1:0]  req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [0] tx_valid, [8:1] tx_byte, [9] transmit_mode, [10] fast_rate,
   // [13:11] status, [15:14] zero
   output logic [15:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   iees_pkg::req_type       req;
   iees_pkg::item_type      item;
   iees_pkg::rsp_type       rsp;
   iees_pkg::ctrl_stat_type stat;
   logic                    item_accept;

   assign csr_ready   = 1'b1;
   assign item_accept = req_tvalid && req_tready;

   always_comb begin
      req.action           = req_tuser;
      req.arbitration_lost = req_tdata[0];
      req.address_match    = req_tdata[1];
      req.slave_transmit   = req_tdata[2];
      req.master_nack      = req_tdata[3];
      req.bus_busy         = req_tdata[4];
      req.rx_byte          = req_tdata[12:5];
      req.load_address     = req_tdata[28:13];
      req.load_byte        = req_tdata[36:29];
   end

   iees_ctrl #(
      .IMAGE_DEPTH (IMAGE_DEPTH)
   ) u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .item_accept (item_accept),
      .req         (req),
      .csr_write   (csr_valid),
      .csr_index   (csr_index),
      .csr_data    (csr_data),
      .item_out    (item),
      .stat        (stat)
   );

   iees_pipe #(
      .IMAGE_DEPTH (IMAGE_DEPTH)
   ) u_pipe (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .in_item   (item),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_rsp   (rsp)
   );

   assign rsp_tdata = {2'b00, rsp.status, rsp.fast_rate, rsp.transmit_mode,
                       rsp.tx_byte, rsp.tx_valid};

   // a finished transaction never resumes
   a_finished_sticky: assert property (@(posedge clock) disable iff (reset)
      stat.phase == iees_pkg::PH_FINISHED |=> stat.phase == iees_pkg::PH_FINISHED)
      else $error("finished phase left");

   // waiting for stop is only entered after a nack, which ends sending
   a_wait_not_sending: assert property (@(posedge clock) disable iff (reset)
      stat.phase == iees_pkg::PH_WAIT_STOP |-> !stat.sending)
      else $error("sending while waiting for stop");

   // back-pressure only when the result stage is held by the receiver
   a_ready_only_stalled: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> rsp_tvalid && !rsp_tready)
      else $error("input stalled without output stall");

   // no byte shown without the transmit flag
   a_tx_byte_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tdata[0] |-> rsp_tdata[8:1] == 8'h00)
      else $error("transmit byte without transmit flag");

endmodule

[tb/sv/tb_top.sv]
// self-checking testbench for the i2c eeprom image server: stream traffic against a predictor
module tb_top;
   import iees_pkg::*;

   localparam int IMAGE_DEPTH = 65536;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_PER_PHASE = 320;
   localparam logic [1:0] ACT_UNUSED = 2'd3;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [39:0] req_tdata = '0;
   logic [1:0]  req_tuser = ACT_LOAD;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [1:0]  csr_index = CSR_RESET_TICKS;
   logic [15:0] csr_data = '0;

   i2c_eeprom_slave_image_server_unit #(
      .IMAGE_DEPTH(IMAGE_DEPTH)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // predicted slave state and register copies
   logic [7:0]  mdl_image [0:IMAGE_DEPTH-1];
   bit          mdl_written [0:IMAGE_DEPTH-1];
   logic [15:0] mdl_index;
   logic        mdl_expect_high;
   logic        mdl_sending;
   logic        mdl_fast;
   logic [15:0] mdl_ticks;
   phase_type   mdl_phase;
   logic [2:0]  mdl_status;
   logic        mdl_bus_seen;
   logic [15:0] cfg_reset_ticks;
   logic [15:0] cfg_transfer_ticks;
   logic [15:0] cfg_fast_index;

   req_type     req_backlog[$];
   rsp_type     rsp_due[$];
   logic [15:0] loaded_addr[$];

   int          send_idle_pct = 0;
   int          recv_stall_pct = 0;
   int          fail_count = 0;
   int          cycle_count = 0;
   req_type     drive_word;
   rsp_type     want_word;
   rsp_type     got_word;

   function automatic rsp_type eeprom_response(input req_type w);
      rsp_type o;
      logic tx_v;
      logic [7:0] tx_b;
      tx_v = 1'b0;
      tx_b = 8'h00;
      case (w.action)
         ACT_LOAD: begin
            if (int'(w.load_address) < IMAGE_DEPTH) begin
               mdl_image[int'(w.load_address)] = w.load_byte;
               mdl_written[int'(w.load_address)] = 1'b1;
            end
         end
         ACT_BUS: begin
            if (mdl_phase == PH_WAIT_STOP) begin
               if (!w.bus_busy) begin
                  mdl_phase = PH_FINISHED;
                  mdl_status = ST_DONE_OK;
               end
            end else if (mdl_phase == PH_RUNNING) begin
               mdl_bus_seen = 1'b1;
               if (w.arbitration_lost) begin
                  mdl_phase = PH_FINISHED;
                  mdl_status = ST_ARB_LOST;
               end else if (w.address_match) begin
                  if (w.slave_transmit) begin
                     mdl_sending = 1'b1;
                     tx_v = 1'b1;
                     tx_b = mdl_image[int'(mdl_index) % IMAGE_DEPTH];
                     mdl_index = mdl_index + 16'd1;
                  end else begin
                     mdl_sending = 1'b0;
                     mdl_index = 16'd0;
                     mdl_expect_high = 1'b1;
                  end
                  mdl_ticks = cfg_transfer_ticks;
               end else begin
                  // byte complete
                  if (mdl_index == cfg_fast_index) mdl_fast = 1'b1;
                  if (mdl_sending) begin
                     if (!w.master_nack) begin
                        tx_v = 1'b1;
                        tx_b = mdl_image[int'(mdl_index) % IMAGE_DEPTH];
                        mdl_index = mdl_index + 16'd1;
                     end else begin
                        mdl_sending = 1'b0;
                        if (mdl_index > 16'd1) mdl_phase = PH_WAIT_STOP;
                     end
                  end else if (mdl_expect_high) begin
                     mdl_index = {w.rx_byte, 8'h00};
                     mdl_expect_high = 1'b0;
                  end else begin
                     mdl_index = mdl_index | {8'h00, w.rx_byte};
                  end
                  mdl_ticks = cfg_transfer_ticks;
               end
            end
         end
         ACT_TICK: begin
            if (mdl_phase != PH_FINISHED) begin
               if (mdl_ticks <= 16'd1) begin
                  if (mdl_phase == PH_WAIT_STOP) mdl_status = ST_STOP_TIMEOUT;
                  else if (mdl_index != 16'd0) mdl_status = ST_TRANSFER_TIMEOUT;
                  else mdl_status = ST_RESET_TIMEOUT;
                  mdl_phase = PH_FINISHED;
               end else begin
                  mdl_ticks = mdl_ticks - 16'd1;
               end
            end
         end
         default: ;
      endcase
      o.tx_valid = tx_v;
      o.tx_byte = tx_b;
      o.transmit_mode = mdl_sending;
      o.fast_rate = mdl_fast;
      o.status = mdl_status;
      return o;
   endfunction

   function automatic req_type any_word();
      req_type r;
      r.action = 2'($urandom_range(0, 3));
      r.arbitration_lost = 1'($urandom_range(0, 1));
      r.address_match = 1'($urandom_range(0, 1));
      r.slave_transmit = 1'($urandom_range(0, 1));
      r.master_nack = 1'($urandom_range(0, 1));
      r.bus_busy = 1'($urandom_range(0, 1));
      r.rx_byte = 8'($urandom);
      r.load_address = 16'($urandom);
      r.load_byte = 8'($urandom);
      return r;
   endfunction

   function automatic req_type bus_word(input logic match, input logic stx,
                                        input logic nack, input logic [7:0] rx);
      req_type r;
      r = any_word();
      r.action = ACT_BUS;
      r.arbitration_lost = 1'b0;
      r.address_match = match;
      r.slave_transmit = stx;
      r.master_nack = nack;
      r.rx_byte = rx;
      return r;
   endfunction

   function automatic req_type load_word(input logic [15:0] addr, input logic [7:0] data);
      req_type r;
      r = any_word();
      r.action = ACT_LOAD;
      r.load_address = addr;
      r.load_byte = data;
      return r;
   endfunction

   function automatic req_type tick_word();
      req_type r;
      r = any_word();
      r.action = ACT_TICK;
      return r;
   endfunction

   // queue a word and its predicted response; an image read of an entry
   // never loaded is preceded by a load of that entry
   task automatic emit_word(input req_type w);
      int addr;
      if (w.action == ACT_BUS && mdl_phase == PH_RUNNING && !w.arbitration_lost &&
          ((w.address_match && w.slave_transmit) ||
           (!w.address_match && mdl_sending && !w.master_nack))) begin
         addr = int'(mdl_index) % IMAGE_DEPTH;
         if (!mdl_written[addr]) emit_word(load_word(16'(addr), 8'($urandom)));
      end
      req_backlog.push_back(w);
      rsp_due.push_back(eeprom_response(w));
   endtask

   task automatic write_csr(input logic [1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      case (idx)
         CSR_RESET_TICKS: begin
            cfg_reset_ticks = value;
            if (mdl_phase == PH_RUNNING && !mdl_bus_seen) mdl_ticks = value;
         end
         CSR_TRANSFER_TICKS: cfg_transfer_ticks = value;
         CSR_FAST_INDEX: cfg_fast_index = value;
         default: ;
      endcase
   endtask

   task automatic wait_drained();
      while (req_backlog.size() != 0 || rsp_due.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic setup_phase(input int send_pct, input int recv_pct,
                              input logic [15:0] reset_ticks,
                              input logic [15:0] transfer_ticks,
                              input logic [15:0] fast_index);
      wait_drained();
      send_idle_pct = send_pct;
      recv_stall_pct = recv_pct;
      write_csr(CSR_RESET_TICKS, reset_ticks);
      write_csr(CSR_TRANSFER_TICKS, transfer_ticks);
      write_csr(CSR_FAST_INDEX, fast_index);
   endtask

   task automatic directed_items();
      req_type w;
      emit_word(load_word(16'h0000, 8'h00));
      emit_word(load_word(16'hffff, 8'hff));
      emit_word(load_word(16'h0001, 8'ha5));
      emit_word(load_word(16'h8000, 8'h5a));
      emit_word(tick_word());
      w = any_word();
      w.action = ACT_UNUSED;
      emit_word(w);
      // address ffff, then read across the index wrap and the fast switch
      emit_word(bus_word(1'b1, 1'b0, 1'b0, 8'h00));
      emit_word(bus_word(1'b0, 1'b0, 1'b1, 8'hff));
      emit_word(bus_word(1'b0, 1'b0, 1'b0, 8'hff));
      emit_word(bus_word(1'b1, 1'b1, 1'b0, 8'h00));
      repeat (4) emit_word(bus_word(1'b0, 1'b1, 1'b0, 8'h00));
      // repeated start, address 8000 with a later byte ored in
      emit_word(bus_word(1'b1, 1'b0, 1'b0, 8'h00));
      emit_word(bus_word(1'b0, 1'b0, 1'b0, 8'h80));
      emit_word(bus_word(1'b0, 1'b0, 1'b0, 8'h00));
      emit_word(bus_word(1'b0, 1'b0, 1'b0, 8'h00));
      // single byte read then nack: stays running
      emit_word(bus_word(1'b1, 1'b0, 1'b0, 8'h00));
      emit_word(bus_word(1'b0, 1'b0, 1'b0, 8'h00));
      emit_word(bus_word(1'b0, 1'b0, 1'b0, 8'h00));
      emit_word(bus_word(1'b1, 1'b1, 1'b0, 8'h00));
      emit_word(bus_word(1'b0, 1'b1, 1'b1, 8'h00));
      emit_word(tick_word());
      emit_word(bus_word(1'b0, 1'b0, 1'b0, 8'h3c));
   endtask

   task automatic random_items(input int n);
      int done_count;
      int pick;
      int k;
      logic [15:0] addr;
      req_type w;
      done_count = 0;
      while (done_count < n) begin
         pick = $urandom_range(0, 99);
         if (pick < 35) begin
            // write direction: high then low address byte
            emit_word(bus_word(1'b1, 1'b0, 1'($urandom_range(0, 1)), 8'($urandom)));
            if (loaded_addr.size() > 0 && $urandom_range(0, 1) == 1)
               addr = loaded_addr[$urandom_range(0, loaded_addr.size() - 1)];
            else
               addr = 16'($urandom);
            emit_word(bus_word(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               addr[15:8]));
            emit_word(bus_word(1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               addr[7:0]));
            done_count += 3;
            if ($urandom_range(0, 4) == 0) begin
               emit_word(bus_word(1'b0, 1'b0, 1'($urandom_range(0, 1)), 8'($urandom)));
               done_count += 1;
            end
         end else if (pick < 65) begin
            // read direction from the current index
            emit_word(bus_word(1'b1, 1'b1, 1'($urandom_range(0, 1)), 8'($urandom)));
            k = $urandom_range(0, 6);
            repeat (k) emit_word(bus_word(1'b0, 1'($urandom_range(0, 1)), 1'b0,
                                          8'($urandom)));
            done_count += k + 1;
            if (mdl_index <= 16'd1 && $urandom_range(0, 1) == 1) begin
               emit_word(bus_word(1'b0, 1'($urandom_range(0, 1)), 1'b1, 8'($urandom)));
               done_count += 1;
            end
         end else if (pick < 77) begin
            addr = 16'($urandom);
            emit_word(load_word(addr, 8'($urandom)));
            loaded_addr.push_back(addr);
            if (loaded_addr.size() > 64) void'(loaded_addr.pop_front());
            done_count += 1;
         end else if (pick < 90) begin
            // keep clear of the timeouts until the closing sequence
            if (mdl_phase == PH_RUNNING && mdl_ticks > 16'd1) begin
               emit_word(tick_word());
               done_count += 1;
            end
         end else begin
            w = any_word();
            w.action = ACT_BUS;
            w.arbitration_lost = 1'b0;
            if (mdl_sending && mdl_index > 16'd1) w.master_nack = 1'b0;
            if ($urandom_range(0, 9) == 0) w.action = ACT_UNUSED;
            else done_count += 1;
            emit_word(w);
         end
      end
   endtask

   task automatic enter_wait_stop();
      emit_word(bus_word(1'b1, 1'b1, 1'b0, 8'($urandom)));
      while (mdl_index <= 16'd1) emit_word(bus_word(1'b0, 1'b1, 1'b0, 8'($urandom)));
      emit_word(bus_word(1'b0, 1'b1, 1'b1, 8'($urandom)));
   endtask

   // one closing outcome per run, then words that a finished slave ignores
   task automatic closing_items();
      int ending;
      req_type w;
      ending = $urandom_range(0, 4);
      case (ending)
         0, 4: begin
            enter_wait_stop();
            repeat ($urandom_range(1, 4)) begin
               w = any_word();
               w.action = ACT_BUS;
               w.bus_busy = 1'b1;
               emit_word(w);
            end
            if (ending == 0) begin
               w = any_word();
               w.action = ACT_BUS;
               w.bus_busy = 1'b0;
               emit_word(w);
            end
         end
         1: begin
            w = any_word();
            w.action = ACT_BUS;
            w.arbitration_lost = 1'b1;
            emit_word(w);
         end
         2: begin
            emit_word(bus_word(1'b1, 1'b0, 1'b0, 8'h00));
            emit_word(bus_word(1'b0, 1'b0, 1'b0, 8'($urandom_range(1, 255))));
         end
         default: emit_word(bus_word(1'b1, 1'b0, 1'b0, 8'h00));
      endcase
      while (mdl_phase != PH_FINISHED) emit_word(tick_word());
      repeat (40) emit_word(any_word());
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else if (!req_tvalid || req_tready) begin
         if (req_backlog.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
            drive_word = req_backlog.pop_front();
            req_tvalid <= 1'b1;
            req_tuser <= drive_word.action;
            req_tdata <= {3'b000, drive_word.load_byte, drive_word.load_address,
                          drive_word.rx_byte, drive_word.bus_busy, drive_word.master_nack,
                          drive_word.slave_transmit, drive_word.address_match,
                          drive_word.arbitration_lost};
         end else begin
            req_tvalid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_word.tx_valid = rsp_tdata[0];
         got_word.tx_byte = rsp_tdata[8:1];
         got_word.transmit_mode = rsp_tdata[9];
         got_word.fast_rate = rsp_tdata[10];
         got_word.status = rsp_tdata[13:11];
         if (rsp_due.size() == 0) begin
            fail_count += 1;
            if (fail_count <= 10)
               $display("unexpected response word %04h", rsp_tdata);
         end else begin
            want_word = rsp_due.pop_front();
            if (got_word.tx_valid !== want_word.tx_valid ||
                got_word.tx_byte !== want_word.tx_byte ||
                got_word.transmit_mode !== want_word.transmit_mode ||
                got_word.fast_rate !== want_word.fast_rate ||
                got_word.status !== want_word.status) begin
               fail_count += 1;
               if (fail_count <= 10)
                  $display({"mismatch: expected txv %0d byte %02h mode %0d fast %0d ",
                            "status %0d, got txv %0d byte %02h mode %0d fast %0d status %0d"},
                           want_word.tx_valid, want_word.tx_byte, want_word.transmit_mode,
                           want_word.fast_rate, want_word.status, got_word.tx_valid,
                           got_word.tx_byte, got_word.transmit_mode, got_word.fast_rate,
                           got_word.status);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   initial begin
      cfg_reset_ticks = RESET_TICKS_DEFAULT;
      cfg_transfer_ticks = TRANSFER_TICKS_DEFAULT;
      cfg_fast_index = FAST_INDEX_DEFAULT;
      mdl_index = 16'd0;
      mdl_expect_high = 1'b1;
      mdl_sending = 1'b0;
      mdl_fast = 1'b0;
      mdl_ticks = RESET_TICKS_DEFAULT;
      mdl_phase = PH_RUNNING;
      mdl_status = ST_RUNNING;
      mdl_bus_seen = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // the reset tick write lands before any bus word, so it reloads the count
      setup_phase(0, 0, 16'hffff, 16'd300, 16'd3);
      directed_items();
      random_items(RANDOM_PER_PHASE);
      setup_phase(55, 0, 16'd200, 16'hffff, 16'h0000);
      random_items(RANDOM_PER_PHASE);
      setup_phase(0, 55, 16'd1, 16'd1, 16'hffff);
      random_items(RANDOM_PER_PHASE);
      setup_phase(34, 34, RESET_TICKS_DEFAULT, 16'd20, 16'($urandom));
      random_items(RANDOM_PER_PHASE);
      closing_items();
      wait_drained();

      if (fail_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

[files.f]
design/iees_pkg.sv
design/iees_ram.sv
design/iees_ctrl.sv
design/iees_pipe.sv
design/i2c_eeprom_slave_image_server_unit.sv
tb/sv/tb_top.sv
